// ----- rtl/gne_pkg.sv -----
`timescale 1ns / 1ps
package gne_pkg;

  localparam logic [2:0] KIND_CLEAR  = 3'd0;
  localparam logic [2:0] KIND_DEFINE = 3'd1;
  localparam logic [2:0] KIND_ADD    = 3'd2;
  localparam logic [2:0] KIND_OUTPUT = 3'd3;
  localparam logic [2:0] KIND_FORCE  = 3'd4;
  localparam logic [2:0] KIND_RUN    = 3'd5;

  localparam logic [1:0] NCLS_PI    = 2'd0;
  localparam logic [1:0] NCLS_CONST = 2'd1;
  localparam logic [1:0] NCLS_GATE  = 2'd2;

  localparam logic [1:0] CLS_UNDEF = 2'd0;
  localparam logic [1:0] CLS_PI    = 2'd1;
  localparam logic [1:0] CLS_CONST = 2'd2;
  localparam logic [1:0] CLS_GATE  = 2'd3;

  localparam logic [2:0] GT_AND  = 3'd0;
  localparam logic [2:0] GT_OR   = 3'd1;
  localparam logic [2:0] GT_NAND = 3'd2;
  localparam logic [2:0] GT_NOR  = 3'd3;
  localparam logic [2:0] GT_NOT  = 3'd4;
  localparam logic [2:0] GT_BUFF = 3'd5;
  localparam logic [2:0] GT_XOR  = 3'd6;
  localparam logic [2:0] GT_XNOR = 3'd7;

  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_CYCLE    = 4'd1;
  localparam logic [3:0] ST_NOINPUT  = 4'd2;
  localparam logic [3:0] ST_ARITY    = 4'd3;
  localparam logic [3:0] ST_UNDEF    = 4'd4;
  localparam logic [3:0] ST_REDEF    = 4'd5;
  localparam logic [3:0] ST_CONFLICT = 4'd6;
  localparam logic [3:0] ST_RANGE    = 4'd7;
  localparam logic [3:0] ST_NOTGATE  = 4'd8;

  typedef enum logic [3:0] {
    OP_CLEAR, OP_DEF_PI, OP_DEF_CONST, OP_DEF_GATE, OP_ADD,
    OP_APPEND, OP_FORCE, OP_RUN, OP_REJECT
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [9:0]  node;
    logic [2:0]  gt;
    logic        cv;
    logic [9:0]  src;
    logic [63:0] pi_bits;
  } item_t;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_LD, S_RESP, S_OC, S_OC1, S_OC2, S_HINIT,
    S_NRD, S_NCHK, S_ERD, S_ES, S_EL, S_NEND, S_NADV, S_CHK,
    S_PI, S_PI1, S_QRD, S_Q1, S_Q2, S_FRD, S_FV, S_FA, S_QW,
    S_H1, S_E1, S_E2, S_FIN, S_OUT, S_OUT1, S_OUT2
  } state_t;

  function automatic logic gate_eval(logic [2:0] t, logic a, logic o, logic x);
    logic r;
    case (t)
      GT_AND:  r = a;
      GT_OR:   r = o;
      GT_NAND: r = ~a;
      GT_NOR:  r = ~o;
      GT_NOT:  r = ~x;
      GT_BUFF: r = x;
      GT_XOR:  r = x;
      default: r = ~x;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/gne_front.sv -----
`timescale 1ns / 1ps
module gne_front import gne_pkg::*; #(
  parameter int MAX_NODES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  kind,
  input  logic [9:0]  node,
  input  logic [1:0]  node_class,
  input  logic [2:0]  gate_type,
  input  logic        const_value,
  input  logic [9:0]  source,
  input  logic [63:0] pi_bits,
  input  logic        hold,
  output logic        q_valid,
  output item_t       q_item,
  input  logic        q_pop
);

  item_t       qmem [2];
  logic        wp, rp;
  logic [1:0]  cnt;
  item_t       cls_item;
  logic        node_ok, src_ok, push;

  always_comb begin
    node_ok = 32'(node) < MAX_NODES;
    src_ok  = 32'(source) < MAX_NODES;
    cls_item.node    = node;
    cls_item.gt      = gate_type;
    cls_item.cv      = const_value;
    cls_item.src     = source;
    cls_item.pi_bits = pi_bits;
    cls_item.op      = OP_REJECT;
    case (kind)
      KIND_CLEAR: cls_item.op = OP_CLEAR;
      KIND_DEFINE: begin
        if (node_ok) begin
          case (node_class)
            NCLS_PI:    cls_item.op = OP_DEF_PI;
            NCLS_CONST: cls_item.op = OP_DEF_CONST;
            NCLS_GATE:  cls_item.op = OP_DEF_GATE;
            default:    cls_item.op = OP_REJECT;
          endcase
        end
      end
      KIND_ADD:    if (node_ok && src_ok) cls_item.op = OP_ADD;
      KIND_OUTPUT: if (node_ok) cls_item.op = OP_APPEND;
      KIND_FORCE:  if (node_ok) cls_item.op = OP_FORCE;
      KIND_RUN:    cls_item.op = OP_RUN;
      default:     cls_item.op = OP_REJECT;
    endcase
  end

  assign in_ready = (cnt != 2'd2) && !hold;
  assign push     = in_valid && in_ready;
  assign q_valid  = cnt != 2'd0;
  assign q_item   = qmem[rp];

  always_ff @(posedge clk) begin
    if (push) qmem[wp] <= cls_item;
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (q_pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(q_pop);
    end
  end

endmodule

// ----- rtl/gne_back.sv -----
`timescale 1ns / 1ps
module gne_back import gne_pkg::*; #(
  parameter int MAX_NODES = 1024,
  parameter int MAX_FANIN = 8,
  parameter int MAX_PI    = 64,
  parameter int MAX_PO    = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  item_t      q_item,
  output logic       q_pop,
  output logic       clearing,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       po_value,
  output logic [5:0] out_position,
  output logic       last,
  output logic [3:0] status
);

  localparam int NW  = $clog2(MAX_NODES);
  localparam int FW  = $clog2(MAX_FANIN);
  localparam int CW  = $clog2(MAX_FANIN + 1);
  localparam int EW  = NW + FW;
  localparam int NMW = 5 + CW;
  localparam int PIA = (MAX_PI > 1) ? $clog2(MAX_PI) : 1;
  localparam int POA = (MAX_PO > 1) ? $clog2(MAX_PO) : 1;
  localparam int PIC = $clog2(MAX_PI + 1);
  localparam int POC = $clog2(MAX_PO + 1);
  localparam int QW  = NW + 1;
  localparam int CTW = (NW + 1 > 7) ? NW + 1 : 7;

  // memories
  logic [NMW-1:0] nmem [MAX_NODES];
  logic           vmem [MAX_NODES];
  logic [NW-1:0]  fmem [MAX_NODES * (1 << FW)];
  logic [NW-1:0]  ilst [MAX_PI];
  logic [NW-1:0]  olst [MAX_PO];
  logic [CW-1:0]  pmem [MAX_NODES];
  logic [EW:0]    hmem [MAX_NODES];
  logic [EW:0]    xmem [MAX_NODES * (1 << FW)];
  logic [NW-1:0]  rmem [MAX_NODES];

  logic           nm_we, nm_re; logic [NW-1:0] nm_wa, nm_ra; logic [NMW-1:0] nm_wd, nm_rd;
  logic           vm_we, vm_re; logic [NW-1:0] vm_wa, vm_ra; logic vm_wd, vm_rd;
  logic           fi_we, fi_re; logic [EW-1:0] fi_wa, fi_ra; logic [NW-1:0] fi_wd, fi_rd;
  logic           il_we, il_re; logic [PIA-1:0] il_wa, il_ra; logic [NW-1:0] il_wd, il_rd;
  logic           ol_we, ol_re; logic [POA-1:0] ol_wa, ol_ra; logic [NW-1:0] ol_wd, ol_rd;
  logic           pd_we, pd_re; logic [NW-1:0] pd_wa, pd_ra; logic [CW-1:0] pd_wd, pd_rd;
  logic           hd_we, hd_re; logic [NW-1:0] hd_wa, hd_ra; logic [EW:0] hd_wd, hd_rd;
  logic           nx_we, nx_re; logic [EW-1:0] nx_wa, nx_ra; logic [EW:0] nx_wd, nx_rd;
  logic           rq_we, rq_re; logic [NW-1:0] rq_wa, rq_ra, rq_wd, rq_rd;

  always_ff @(posedge clk) begin
    if (nm_we) nmem[nm_wa] <= nm_wd;
    if (nm_re) nm_rd <= nmem[nm_ra];
    if (vm_we) vmem[vm_wa] <= vm_wd;
    if (vm_re) vm_rd <= vmem[vm_ra];
    if (fi_we) fmem[fi_wa] <= fi_wd;
    if (fi_re) fi_rd <= fmem[fi_ra];
    if (il_we) ilst[il_wa] <= il_wd;
    if (il_re) il_rd <= ilst[il_ra];
    if (ol_we) olst[ol_wa] <= ol_wd;
    if (ol_re) ol_rd <= olst[ol_ra];
    if (pd_we) pmem[pd_wa] <= pd_wd;
    if (pd_re) pd_rd <= pmem[pd_ra];
    if (hd_we) hmem[hd_wa] <= hd_wd;
    if (hd_re) hd_rd <= hmem[hd_ra];
    if (nx_we) xmem[nx_wa] <= nx_wd;
    if (nx_re) nx_rd <= xmem[nx_ra];
    if (rq_we) rmem[rq_wa] <= rq_wd;
    if (rq_re) rq_rd <= rmem[rq_ra];
  end

  // sequencer registers
  state_t         state, state_next;
  item_t          item, item_next;
  logic [CTW-1:0] ctr, ctr_next;
  logic [CW-1:0]  slot, slot_next, ccnt, ccnt_next, pcnt, pcnt_next;
  logic [NW-1:0]  cur, cur_next, src, src_next;
  logic [2:0]     ctype, ctype_next;
  logic [EW-1:0]  eid, eid_next;
  logic [QW-1:0]  gates, gates_next, done, done_next, qh, qh_next, qt, qt_next;
  logic           f_undef, f_undef_next, f_noin, f_noin_next, f_arity, f_arity_next;
  logic           acc_a, acc_a_next, acc_o, acc_o_next, acc_x, acc_x_next;
  logic [PIC-1:0] icnt, icnt_next;
  logic [POC-1:0] ocnt, ocnt_next;
  logic           clr_resp, clr_resp_next;
  logic [3:0]     rstat, rstat_next;

  logic           emit_req, emit_ok, e_val, e_last;
  logic [5:0]     e_pos;
  logic [3:0]     e_st;

  logic [1:0]     rd_cls;
  logic [2:0]     rd_gt;
  logic [CW-1:0]  rd_fc;
  logic [NW-1:0]  item_n, e_dst;
  logic [EW-1:0]  cur_eid;

  assign rd_cls   = nm_rd[CW+4:CW+3];
  assign rd_gt    = nm_rd[CW+2:CW];
  assign rd_fc    = nm_rd[CW-1:0];
  assign item_n   = NW'(item.node);
  assign e_dst    = eid[EW-1:FW];
  assign cur_eid  = {cur, slot[FW-1:0]};
  assign emit_ok  = emit_req && (!out_valid || out_ready);
  assign clearing = state == S_CLR;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      ctr      <= '0;
      clr_resp <= 1'b0;
      icnt     <= '0;
      ocnt     <= '0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      ctr      <= ctr_next;
      clr_resp <= clr_resp_next;
      icnt     <= icnt_next;
      ocnt     <= ocnt_next;
      if (emit_ok) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
    if (emit_ok) begin
      po_value     <= e_val;
      out_position <= e_pos;
      last         <= e_last;
      status       <= e_st;
    end
    item <= item_next; slot <= slot_next; ccnt <= ccnt_next; pcnt <= pcnt_next;
    cur <= cur_next; src <= src_next; ctype <= ctype_next; eid <= eid_next;
    gates <= gates_next; done <= done_next; qh <= qh_next; qt <= qt_next;
    f_undef <= f_undef_next; f_noin <= f_noin_next; f_arity <= f_arity_next;
    acc_a <= acc_a_next; acc_o <= acc_o_next; acc_x <= acc_x_next;
    rstat <= rstat_next;
  end

  always_comb begin
    state_next = state; item_next = item; ctr_next = ctr; slot_next = slot;
    ccnt_next = ccnt; pcnt_next = pcnt; cur_next = cur; src_next = src;
    ctype_next = ctype; eid_next = eid; gates_next = gates; done_next = done;
    qh_next = qh; qt_next = qt; f_undef_next = f_undef; f_noin_next = f_noin;
    f_arity_next = f_arity; acc_a_next = acc_a; acc_o_next = acc_o;
    acc_x_next = acc_x; icnt_next = icnt; ocnt_next = ocnt;
    clr_resp_next = clr_resp; rstat_next = rstat;
    q_pop = 1'b0; emit_req = 1'b0; e_val = 1'b0; e_pos = '0; e_last = 1'b1;
    e_st = rstat;
    nm_we = 1'b0; nm_re = 1'b0; nm_wa = item_n; nm_ra = item_n; nm_wd = '0;
    vm_we = 1'b0; vm_re = 1'b0; vm_wa = item_n; vm_ra = item_n; vm_wd = item.cv;
    fi_we = 1'b0; fi_re = 1'b0; fi_wa = cur_eid; fi_ra = cur_eid; fi_wd = NW'(item.src);
    il_we = 1'b0; il_re = 1'b0; il_wa = icnt[PIA-1:0]; il_ra = ctr[PIA-1:0];
    il_wd = item_n;
    ol_we = 1'b0; ol_re = 1'b0; ol_wa = ocnt[POA-1:0]; ol_ra = ctr[POA-1:0];
    ol_wd = item_n;
    pd_we = 1'b0; pd_re = 1'b0; pd_wa = cur; pd_ra = e_dst; pd_wd = pcnt;
    hd_we = 1'b0; hd_re = 1'b0; hd_wa = src; hd_ra = fi_rd; hd_wd = {1'b1, cur_eid};
    nx_we = 1'b0; nx_re = 1'b0; nx_wa = cur_eid; nx_ra = eid; nx_wd = hd_rd;
    rq_we = 1'b0; rq_re = 1'b0; rq_wa = qt[NW-1:0]; rq_ra = qh[NW-1:0]; rq_wd = cur;

    case (state)
      S_CLR: begin
        nm_we = 1'b1;
        nm_wa = ctr[NW-1:0];
        nm_wd = {CLS_UNDEF, 3'd0, CW'(0)};
        if (ctr == CTW'(MAX_NODES - 1)) begin
          ctr_next = '0;
          rstat_next = ST_OK;
          state_next = clr_resp ? S_RESP : S_IDLE;
        end else begin
          ctr_next = ctr + CTW'(1);
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          item_next = q_item;
          nm_re = 1'b1; nm_ra = NW'(q_item.node);
          vm_re = 1'b1; vm_ra = NW'(q_item.node);
          ctr_next = '0;
          case (q_item.op)
            OP_CLEAR: begin
              icnt_next = '0;
              ocnt_next = '0;
              clr_resp_next = 1'b1;
              state_next = S_CLR;
            end
            OP_REJECT: begin
              rstat_next = ST_RANGE;
              state_next = S_RESP;
            end
            OP_RUN:  state_next = S_OC;
            default: state_next = S_LD;
          endcase
        end
      end
      S_LD: begin
        rstat_next = ST_OK;
        state_next = S_RESP;
        case (item.op)
          OP_DEF_PI: begin
            if (rd_cls != CLS_UNDEF && rd_cls != CLS_PI) rstat_next = ST_REDEF;
            else if (rd_cls == CLS_PI) rstat_next = ST_OK;
            else if (icnt >= PIC'(MAX_PI)) rstat_next = ST_RANGE;
            else begin
              nm_we = 1'b1; nm_wd = {CLS_PI, 3'd0, CW'(0)};
              il_we = 1'b1;
              icnt_next = icnt + PIC'(1);
            end
          end
          OP_DEF_CONST: begin
            if (rd_cls != CLS_UNDEF && rd_cls != CLS_CONST) rstat_next = ST_REDEF;
            else if (rd_cls == CLS_CONST && vm_rd != item.cv) rstat_next = ST_CONFLICT;
            else begin
              nm_we = 1'b1; nm_wd = {CLS_CONST, 3'd0, CW'(0)};
              vm_we = 1'b1;
            end
          end
          OP_DEF_GATE: begin
            if (rd_cls != CLS_UNDEF) rstat_next = ST_REDEF;
            else begin
              nm_we = 1'b1; nm_wd = {CLS_GATE, item.gt, CW'(0)};
            end
          end
          OP_ADD: begin
            if (rd_cls != CLS_GATE) rstat_next = ST_NOTGATE;
            else if (rd_fc >= CW'(MAX_FANIN)) rstat_next = ST_RANGE;
            else begin
              fi_we = 1'b1; fi_wa = {item_n, rd_fc[FW-1:0]};
              nm_we = 1'b1; nm_wd = {CLS_GATE, rd_gt, rd_fc + CW'(1)};
            end
          end
          OP_APPEND: begin
            if (ocnt >= POC'(MAX_PO)) rstat_next = ST_RANGE;
            else begin
              ol_we = 1'b1;
              ocnt_next = ocnt + POC'(1);
            end
          end
          OP_FORCE: begin
            if (rd_cls != CLS_GATE) rstat_next = ST_NOTGATE;
            else begin
              nm_we = 1'b1; nm_wd = {CLS_CONST, rd_gt, CW'(0)};
              vm_we = 1'b1;
            end
          end
          default: rstat_next = ST_RANGE;
        endcase
      end
      S_RESP: begin
        emit_req = 1'b1;
        if (emit_ok) begin
          clr_resp_next = 1'b0;
          state_next = S_IDLE;
        end
      end
      // run: outputs must name defined nodes
      S_OC: begin
        if (ctr == CTW'(ocnt)) begin
          ctr_next = '0;
          state_next = S_HINIT;
        end else begin
          ol_re = 1'b1;
          state_next = S_OC1;
        end
      end
      S_OC1: begin
        nm_re = 1'b1; nm_ra = ol_rd;
        state_next = S_OC2;
      end
      S_OC2: begin
        if (rd_cls == CLS_UNDEF) begin
          rstat_next = ST_UNDEF;
          state_next = S_RESP;
        end else begin
          ctr_next = ctr + CTW'(1);
          state_next = S_OC;
        end
      end
      S_HINIT: begin
        hd_we = 1'b1; hd_wa = ctr[NW-1:0]; hd_wd = '0;
        if (ctr == CTW'(MAX_NODES - 1)) begin
          ctr_next = '0; gates_next = '0; qt_next = '0;
          f_undef_next = 1'b0; f_noin_next = 1'b0; f_arity_next = 1'b0;
          state_next = S_NRD;
        end else begin
          ctr_next = ctr + CTW'(1);
        end
      end
      // node sweep: checks, pending counts, fanout lists, initial ready set
      S_NRD: begin
        nm_re = 1'b1; nm_ra = ctr[NW-1:0];
        cur_next = ctr[NW-1:0];
        state_next = S_NCHK;
      end
      S_NCHK: begin
        if (rd_cls == CLS_GATE) begin
          ctype_next = rd_gt; ccnt_next = rd_fc; pcnt_next = '0; slot_next = '0;
          gates_next = gates + QW'(1);
          if (rd_fc == '0) f_noin_next = 1'b1;
          if ((rd_gt == GT_NOT || rd_gt == GT_BUFF) && rd_fc != CW'(1)) f_arity_next = 1'b1;
          state_next = (rd_fc == '0) ? S_NEND : S_ERD;
        end else begin
          state_next = S_NADV;
        end
      end
      S_ERD: begin
        fi_re = 1'b1;
        state_next = S_ES;
      end
      S_ES: begin
        nm_re = 1'b1; nm_ra = fi_rd;
        hd_re = 1'b1;
        src_next = fi_rd;
        state_next = S_EL;
      end
      S_EL: begin
        if (rd_cls == CLS_UNDEF) f_undef_next = 1'b1;
        if (rd_cls == CLS_GATE) begin
          pcnt_next = pcnt + CW'(1);
          nx_we = 1'b1;
          hd_we = 1'b1;
        end
        slot_next = slot + CW'(1);
        state_next = (slot + CW'(1) == ccnt) ? S_NEND : S_ERD;
      end
      S_NEND: begin
        pd_we = 1'b1;
        if (pcnt == '0) begin
          rq_we = 1'b1;
          qt_next = qt + QW'(1);
        end
        state_next = S_NADV;
      end
      S_NADV: begin
        if (ctr == CTW'(MAX_NODES - 1)) begin
          state_next = S_CHK;
        end else begin
          ctr_next = ctr + CTW'(1);
          state_next = S_NRD;
        end
      end
      S_CHK: begin
        ctr_next = '0;
        if (f_undef) begin
          rstat_next = ST_UNDEF; state_next = S_RESP;
        end else if (f_noin) begin
          rstat_next = ST_NOINPUT; state_next = S_RESP;
        end else begin
          state_next = S_PI;
        end
      end
      S_PI: begin
        if (ctr == CTW'(icnt)) begin
          qh_next = '0; done_next = '0;
          state_next = S_QRD;
        end else begin
          il_re = 1'b1;
          state_next = S_PI1;
        end
      end
      S_PI1: begin
        vm_we = 1'b1; vm_wa = il_rd; vm_wd = item.pi_bits[ctr[5:0]];
        ctr_next = ctr + CTW'(1);
        state_next = S_PI;
      end
      // Kahn walk with evaluation at pop
      S_QRD: begin
        if (qh == qt) state_next = S_FIN;
        else begin
          rq_re = 1'b1;
          state_next = S_Q1;
        end
      end
      S_Q1: begin
        nm_re = 1'b1; nm_ra = rq_rd;
        cur_next = rq_rd;
        state_next = S_Q2;
      end
      S_Q2: begin
        ctype_next = rd_gt; ccnt_next = rd_fc; slot_next = '0;
        acc_a_next = 1'b1; acc_o_next = 1'b0; acc_x_next = 1'b0;
        state_next = (rd_fc == '0) ? S_QW : S_FRD;
      end
      S_FRD: begin
        fi_re = 1'b1;
        state_next = S_FV;
      end
      S_FV: begin
        vm_re = 1'b1; vm_ra = fi_rd;
        state_next = S_FA;
      end
      S_FA: begin
        acc_a_next = acc_a & vm_rd;
        acc_o_next = acc_o | vm_rd;
        acc_x_next = acc_x ^ vm_rd;
        slot_next = slot + CW'(1);
        state_next = (slot + CW'(1) == ccnt) ? S_QW : S_FRD;
      end
      S_QW: begin
        vm_we = 1'b1; vm_wa = cur; vm_wd = gate_eval(ctype, acc_a, acc_o, acc_x);
        hd_re = 1'b1; hd_ra = cur;
        state_next = S_H1;
      end
      S_H1: begin
        if (!hd_rd[EW]) begin
          done_next = done + QW'(1);
          qh_next = qh + QW'(1);
          state_next = S_QRD;
        end else begin
          eid_next = hd_rd[EW-1:0];
          state_next = S_E1;
        end
      end
      S_E1: begin
        pd_re = 1'b1;
        nx_re = 1'b1;
        state_next = S_E2;
      end
      S_E2: begin
        pd_we = 1'b1; pd_wa = e_dst; pd_wd = pd_rd - CW'(1);
        if (pd_rd == CW'(1)) begin
          rq_we = 1'b1; rq_wd = e_dst;
          qt_next = qt + QW'(1);
        end
        if (nx_rd[EW]) begin
          eid_next = nx_rd[EW-1:0];
          state_next = S_E1;
        end else begin
          done_next = done + QW'(1);
          qh_next = qh + QW'(1);
          state_next = S_QRD;
        end
      end
      S_FIN: begin
        ctr_next = '0;
        if (done != gates) begin
          rstat_next = ST_CYCLE; state_next = S_RESP;
        end else if (f_arity) begin
          rstat_next = ST_ARITY; state_next = S_RESP;
        end else if (ocnt == '0) begin
          rstat_next = ST_OK; state_next = S_RESP;
        end else begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        ol_re = 1'b1;
        state_next = S_OUT1;
      end
      S_OUT1: begin
        vm_re = 1'b1; vm_ra = ol_rd;
        state_next = S_OUT2;
      end
      S_OUT2: begin
        emit_req = 1'b1;
        e_val  = vm_rd;
        e_pos  = ctr[5:0];
        e_last = (ctr + CTW'(1)) == CTW'(ocnt);
        e_st   = ST_OK;
        if (emit_ok) begin
          ctr_next = ctr + CTW'(1);
          state_next = e_last ? S_IDLE : S_OUT;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- rtl/gate_netlist_evaluator_top.sv -----
`timescale 1ns / 1ps
// Gate netlist evaluator.
// Input channel (in_valid/in_ready): one command per transfer; kind selects
// clear, define node, add gate input, append output, force constant or run.
// Output channel (out_valid/out_ready): result transfers. Every load command
// returns one status result with last set. A run returns one result per
// primary output (po_value, out_position, last on the final one), or a single
// status result on error or with an empty output list.
// A load command passes the queue, the memory reads started in S_IDLE and the
// checks in S_LD; S_RESP then registers its result, and the next command is
// popped once that result is accepted. A run checks the output list, clears
// the fanout heads, sweeps all nodes, loads input values, walks the ready
// queue evaluating gates and returns outputs. A clear answers after clearing.
// Commands enter a two-entry queue, so the next one can be taken while the
// sequencer works; results leave through an output register, so a stalled
// receiver holds the sequencer but not the queue.
// Reset: a clearing pass marks all nodes undefined;
// in_ready stays low during it and during a clear command.
module gate_netlist_evaluator_top import gne_pkg::*; #(
  parameter int MAX_NODES = 1024,
  parameter int MAX_FANIN = 8,
  parameter int MAX_PI    = 64,
  parameter int MAX_PO    = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  kind,
  input  logic [9:0]  node,
  input  logic [1:0]  node_class,
  input  logic [2:0]  gate_type,
  input  logic        const_value,
  input  logic [9:0]  source,
  input  logic [63:0] pi_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        po_value,
  output logic [5:0]  out_position,
  output logic        last,
  output logic [3:0]  status
);

  logic  q_valid, q_pop, clearing;
  item_t q_item;

  gne_front #(.MAX_NODES(MAX_NODES)) u_front (
    .clk, .rst, .in_valid, .in_ready, .kind, .node, .node_class, .gate_type,
    .const_value, .source, .pi_bits, .hold(clearing), .q_valid, .q_item, .q_pop
  );

  gne_back #(
    .MAX_NODES(MAX_NODES), .MAX_FANIN(MAX_FANIN), .MAX_PI(MAX_PI), .MAX_PO(MAX_PO)
  ) u_back (
    .clk, .rst, .q_valid, .q_item, .q_pop, .clearing, .out_valid, .out_ready,
    .po_value, .out_position, .last, .status
  );

endmodule
